// ===== sv/smbw_pkg.sv =====
// Package for the SMBIOS structure table walker.
// Holds the structure type codes, field offsets and the structs passed between modules.
// No dependencies.
`default_nettype none

package smbw_pkg;

  localparam logic [7:0]  TYPE_PROCESSOR  = 8'd4;
  localparam logic [7:0]  TYPE_MEM_MODULE = 8'd6;
  localparam logic [7:0]  TYPE_MEM_DEVICE = 8'd17;

  localparam logic [15:0] POS_CPU_STATUS  = 16'h0018;
  localparam logic [15:0] POS_INST_SIZE   = 16'h000a;
  localparam logic [15:0] POS_SIZE_LO     = 16'h000c;
  localparam logic [15:0] POS_SIZE_HI     = 16'h000d;
  localparam logic [15:0] POS_LENGTH      = 16'h0001;
  localparam logic [15:0] POS_FIRST_FIELD = 16'h0002;
  localparam logic [15:0] POS_MAX         = 16'hffff;

  localparam logic [2:0]  CPU_STAT_ENABLED = 3'd1;
  localparam int unsigned CPU_POPULATED_BIT = 6;
  localparam logic [6:0]  INST_SIZE_LIMIT  = 7'd22;
  localparam logic [4:0]  KB_SHIFT         = 5'd10;
  localparam logic [15:0] SIZE_UNKNOWN     = 16'hffff;
  localparam int unsigned SIZE_KB_UNIT_BIT = 15;

  localparam logic CFG_TABLE_LENGTH    = 1'b0;
  localparam logic CFG_STRUCTURE_COUNT = 1'b1;

  // Accumulator updates for one header field byte
  typedef struct packed {
    logic        enabled_inc;
    logic        populated_inc;
    logic        size_low_we;
    logic [31:0] old_add;
    logic [31:0] new_add;
  } field_upd_t;

  // Summary delivered on the last byte
  typedef struct packed {
    logic [31:0] memory_kb;
    logic        memory_known;
    logic [7:0]  enabled_sockets;
    logic [7:0]  populated_sockets;
    logic [15:0] structures_seen;
    logic        walk_complete;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/smbw_field_unit.sv =====
// Decodes one header field byte of a processor, memory module or memory device structure.
// Depends on smbw_pkg.
`default_nettype none

module smbw_field_unit (
  input  wire logic [7:0]  struct_type_i,
  input  wire logic [15:0] byte_pos_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [7:0]  size_low_i,
  output smbw_pkg::field_upd_t upd_o
);
  import smbw_pkg::*;

  logic [6:0]  inst_n;
  logic [4:0]  inst_shift;
  logic [15:0] dev_size;

  assign inst_n     = data_i[6:0];
  assign inst_shift = inst_n[4:0] + KB_SHIFT;
  assign dev_size   = {data_i, size_low_i};

  always_comb begin
    upd_o = '0;
    case (struct_type_i)
      TYPE_PROCESSOR: begin
        if (byte_pos_i == POS_CPU_STATUS) begin
          upd_o.enabled_inc   = (data_i[2:0] == CPU_STAT_ENABLED);
          upd_o.populated_inc = data_i[CPU_POPULATED_BIT];
        end
      end
      TYPE_MEM_MODULE: begin
        if (byte_pos_i == POS_INST_SIZE && inst_n != 7'd0 && inst_n < INST_SIZE_LIMIT) begin
          upd_o.old_add = 32'd1 << inst_shift;
        end
      end
      TYPE_MEM_DEVICE: begin
        if (byte_pos_i == POS_SIZE_LO) begin
          upd_o.size_low_we = 1'b1;
        end else if (byte_pos_i == POS_SIZE_HI && dev_size != 16'd0 &&
                     dev_size != SIZE_UNKNOWN) begin
          // bit 15 set: size already in KB, else in MB
          upd_o.new_add = dev_size[SIZE_KB_UNIT_BIT] ? {17'd0, dev_size[14:0]}
                                                     : {6'd0, dev_size, 10'd0};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/smbw_walker.sv =====
// Walk state: offsets, structure framing, terminator search and running totals.
// Depends on smbw_pkg and smbw_field_unit.
`default_nettype none

module smbw_walker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        last_i,
  input  wire logic [15:0] table_length_i,
  input  wire logic [15:0] structure_count_i,
  output smbw_pkg::result_t result_o
);
  import smbw_pkg::*;

  logic [15:0] offset_q, offset_d;
  logic [15:0] index_q, index_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  size_low_q, size_low_d;
  logic        prev_zero_q, prev_zero_d;
  logic        done_q, done_d;
  logic [31:0] new_tot_q, new_tot_d;
  logic [31:0] old_tot_q, old_tot_d;
  logic [7:0]  enabled_q, enabled_d;
  logic [7:0]  populated_q, populated_d;

  logic        limit_now;
  logic        limit_next;
  logic        term;
  field_upd_t  upd;

  assign limit_now  = (offset_q >= table_length_i) || (index_q >= structure_count_i);
  assign limit_next = (offset_d >= table_length_i) || (index_d >= structure_count_i);

  smbw_field_unit u_field (
    .struct_type_i (type_q),
    .byte_pos_i    (pos_q),
    .data_i        (data_i),
    .size_low_i    (size_low_q),
    .upd_o         (upd)
  );

  always_comb begin
    offset_d    = offset_q;
    index_d     = index_q;
    pos_d       = pos_q;
    type_d      = type_q;
    len_d       = len_q;
    size_low_d  = size_low_q;
    prev_zero_d = prev_zero_q;
    done_d      = done_q;
    new_tot_d   = new_tot_q;
    old_tot_d   = old_tot_q;
    enabled_d   = enabled_q;
    populated_d = populated_q;
    term        = 1'b0;

    if (step_i && !done_q) begin
      if (pos_q == 16'd0 && limit_now) begin
        done_d = 1'b1;
      end else begin
        if (offset_q != POS_MAX) begin
          offset_d = offset_q + 16'd1;
        end
        if (pos_q == 16'd0) begin
          type_d     = data_i;
          size_low_d = 8'd0;
        end else if (pos_q == POS_LENGTH) begin
          len_d = data_i;
        end
        // terminator search starts at the formatted length
        term = (pos_q > {8'd0, len_d}) && (data_i == 8'd0) && prev_zero_q;
        if (term) begin
          index_d     = index_q + 16'd1;
          pos_d       = 16'd0;
          prev_zero_d = 1'b0;
        end else begin
          if (pos_q >= POS_FIRST_FIELD) begin
            enabled_d   = enabled_q + {7'd0, upd.enabled_inc};
            populated_d = populated_q + {7'd0, upd.populated_inc};
            old_tot_d   = old_tot_q + upd.old_add;
            new_tot_d   = new_tot_q + upd.new_add;
            if (upd.size_low_we) begin
              size_low_d = data_i;
            end
          end
          prev_zero_d = (data_i == 8'd0);
          if (pos_q != POS_MAX) begin
            pos_d = pos_q + 16'd1;
          end
        end
      end
    end

    result_o.memory_kb         = (new_tot_d != 32'd0) ? new_tot_d : old_tot_d;
    result_o.memory_known      = (new_tot_d != 32'd0) || (old_tot_d != 32'd0);
    result_o.enabled_sockets   = enabled_d;
    result_o.populated_sockets = populated_d;
    result_o.structures_seen   = index_d;
    result_o.walk_complete     = done_d || (pos_d == 16'd0 && limit_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      index_q     <= '0;
      pos_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      size_low_q  <= '0;
      prev_zero_q <= 1'b0;
      done_q      <= 1'b0;
      new_tot_q   <= '0;
      old_tot_q   <= '0;
      enabled_q   <= '0;
      populated_q <= '0;
    end else if (step_i && last_i) begin
      // summary taken this cycle; start a fresh walk
      offset_q    <= '0;
      index_q     <= '0;
      pos_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      size_low_q  <= '0;
      prev_zero_q <= 1'b0;
      done_q      <= 1'b0;
      new_tot_q   <= '0;
      old_tot_q   <= '0;
      enabled_q   <= '0;
      populated_q <= '0;
    end else begin
      offset_q    <= offset_d;
      index_q     <= index_d;
      pos_q       <= pos_d;
      type_q      <= type_d;
      len_q       <= len_d;
      size_low_q  <= size_low_d;
      prev_zero_q <= prev_zero_d;
      done_q      <= done_d;
      new_tot_q   <= new_tot_d;
      old_tot_q   <= old_tot_d;
      enabled_q   <= enabled_d;
      populated_q <= populated_d;
    end
  end

  // once done, the framing state is frozen until the next last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !(step_i && last_i)) |=> (done_q && $stable(index_q) && $stable(offset_q)))
    else $error("walker state moved after walk finished");

  // a terminator always returns to the structure start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (term && !last_i) |=> (pos_q == 16'd0 && !prev_zero_q))
    else $error("terminator did not restart structure framing");

endmodule

`default_nettype wire

// ===== sv/smbios_table_walker.sv =====
// An accepted byte is registered in the input stage and processed by the walker from there;
// the summary for a last byte is loaded into the result register when that byte is processed.
// Throughput: one byte per cycle; the walker update is a single compare/add pass.
// Only a last byte held up by a stalled, still full result register blocks input.
// Reset clears the input stage valid, the walk state, the result valid and both config registers.
// Top level of the SMBIOS structure table walker.
// Depends on smbw_pkg, smbw_walker and smbw_field_unit.
`default_nettype none

module smbios_table_walker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  table_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      memory_kb_o,
  output logic             memory_known_o,
  output logic [7:0]       enabled_sockets_o,
  output logic [7:0]       populated_sockets_o,
  output logic [15:0]      structures_seen_o,
  output logic             walk_complete_o
);
  import smbw_pkg::*;

  logic [15:0] table_length_q;
  logic [15:0] structure_count_q;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        in_take;

  logic        out_valid_q;
  result_t     out_q;
  logic        out_free;
  logic        advance;
  result_t     result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!in_last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q    <= '0;
      structure_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TABLE_LENGTH:    table_length_q    <= cfg_wdata_i;
        CFG_STRUCTURE_COUNT: structure_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= table_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  smbw_walker u_walker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .data_i            (in_byte_q),
    .last_i            (in_last_q),
    .table_length_i    (table_length_q),
    .structure_count_i (structure_count_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && in_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign memory_kb_o         = out_q.memory_kb;
  assign memory_known_o      = out_q.memory_known;
  assign enabled_sockets_o   = out_q.enabled_sockets;
  assign populated_sockets_o = out_q.populated_sockets;
  assign structures_seen_o   = out_q.structures_seen;
  assign walk_complete_o     = out_q.walk_complete;

  // a summary only appears after a last byte went through the walker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("result without a last byte");

  // a processed last byte always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> out_valid_q)
    else $error("last byte processed but no result");

  // input is held back only while a last byte waits in the input stage behind a stalled, full result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && in_last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked last byte");

endmodule

`default_nettype wire
